>>> rtl/core/json_object_stream_framer_core_assert.svh
// assertion macros for the json object stream framer
// no dependencies; included by files that carry concurrent assertions
`ifndef JSON_OBJECT_STREAM_FRAMER_CORE_ASSERT_SVH
`define JSON_OBJECT_STREAM_FRAMER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define JSOF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define JSOF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JSOF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define JSOF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/jsof_pkg.sv
// shared types and constants for the json object stream framer
// no dependencies
`timescale 1ns / 1ps

package jsof_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNCLEAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STALE   = 2'd2;

    localparam logic [CFG_W-1:0] SIZE_LIMIT_RST    = 16'd50000;
    localparam logic [CFG_W-1:0] UNCLEAR_LIMIT_RST = 16'd1000;
    localparam logic [CFG_W-1:0] STALE_TICKS_RST   = 16'd10000;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [3:0] {
        BC_WS,
        BC_N,
        BC_A,
        BC_V,
        BC_UNDER,
        BC_O,
        BC_D,
        BC_E,
        BC_LBRACE,
        BC_RBRACE,
        BC_QUOTE,
        BC_OTHER
    } t_bcls;

    typedef enum logic [3:0] {
        LM_NONE,
        LM_N,
        LM_NA,
        LM_NAV,
        LM_NO,
        LM_NOD,
        LM_NODE,
        LM_HIT,
        LM_CLEAR,
        LM_OTHER
    } t_lead;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       in_object;
        logic       object_last;
        logic       object_bad;
        logic       flushed;
    } t_out_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_val;
        t_bcls      cls;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [CFG_W-1:0] size_limit;
        logic [CFG_W-1:0] unclear_limit;
        logic [CFG_W-1:0] stale_ticks;
    } t_cfg;

endpackage

>>> rtl/core/jsof_front.sv
// front end: accepts input beats, classifies the byte and pushes into the queue
// depends on jsof_pkg
`timescale 1ns / 1ps

module jsof_front (
    input  logic                i_in_valid,
    input  jsof_pkg::t_in_item  i_in_item,
    input  jsof_pkg::t_q_stat   i_q_stat,
    output logic                o_in_stall,
    output logic                o_push,
    output jsof_pkg::t_q_entry  o_push_entry
);

    function automatic jsof_pkg::t_bcls classify(input logic [7:0] b);
        jsof_pkg::t_bcls c;
        unique case (b) inside
            [jsof_pkg::CH_TAB:jsof_pkg::CH_CR], jsof_pkg::CH_SPACE: c = jsof_pkg::BC_WS;
            jsof_pkg::CH_N:      c = jsof_pkg::BC_N;
            jsof_pkg::CH_A:      c = jsof_pkg::BC_A;
            jsof_pkg::CH_V:      c = jsof_pkg::BC_V;
            jsof_pkg::CH_UNDER:  c = jsof_pkg::BC_UNDER;
            jsof_pkg::CH_O:      c = jsof_pkg::BC_O;
            jsof_pkg::CH_D:      c = jsof_pkg::BC_D;
            jsof_pkg::CH_E:      c = jsof_pkg::BC_E;
            jsof_pkg::CH_LBRACE: c = jsof_pkg::BC_LBRACE;
            jsof_pkg::CH_RBRACE: c = jsof_pkg::BC_RBRACE;
            jsof_pkg::CH_QUOTE:  c = jsof_pkg::BC_QUOTE;
            default:             c = jsof_pkg::BC_OTHER;
        endcase
        return c;
    endfunction

    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    always_comb begin
        o_push_entry.kind     = i_in_item.kind;
        o_push_entry.byte_val = i_in_item.byte_in;
        o_push_entry.cls      = classify(i_in_item.byte_in);
    end

endmodule

>>> rtl/core/jsof_queue.sv
// two-entry queue between the classifier front end and the framing back end
// depends on jsof_pkg
`timescale 1ns / 1ps

module jsof_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  jsof_pkg::t_q_entry i_push_entry,
    input  logic               i_pop,
    output jsof_pkg::t_q_entry o_head,
    output jsof_pkg::t_q_stat  o_stat
);

    jsof_pkg::t_q_entry            r_mem [jsof_pkg::Q_DEPTH];
    logic [jsof_pkg::Q_AW-1:0]     r_wp;
    logic [jsof_pkg::Q_AW-1:0]     r_rp;
    logic [jsof_pkg::Q_CW-1:0]     r_count;
    logic [jsof_pkg::Q_AW-1:0]     n_wp;
    logic [jsof_pkg::Q_AW-1:0]     n_rp;
    logic [jsof_pkg::Q_CW-1:0]     n_count;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == jsof_pkg::Q_AW'(jsof_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == jsof_pkg::Q_AW'(jsof_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_entry;
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_count == jsof_pkg::Q_CW'(jsof_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

>>> rtl/core/jsof_back.sv
// back end: buffer count, brace depth, lead matcher, idle timer and result register
// depends on jsof_pkg
`timescale 1ns / 1ps

module jsof_back #(
    parameter int COUNT_BITS = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jsof_pkg::t_cfg      i_cfg,
    input  jsof_pkg::t_q_entry  i_head,
    input  jsof_pkg::t_q_stat   i_q_stat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output jsof_pkg::t_out_item o_out_item
);

    localparam int CMP_W = (COUNT_BITS > jsof_pkg::CFG_W) ? COUNT_BITS : jsof_pkg::CFG_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0]       r_cnt;
    logic                        r_inside;
    logic [COUNT_BITS-1:0]       r_depth;
    jsof_pkg::t_lead             r_lead;
    logic                        r_garbage;
    logic [jsof_pkg::CFG_W-1:0]  r_idle;
    logic                        r_out_valid;
    jsof_pkg::t_out_item         r_out_item;

    logic [COUNT_BITS-1:0]       n_cnt;
    logic                        n_inside;
    logic [COUNT_BITS-1:0]       n_depth;
    jsof_pkg::t_lead             n_lead;
    logic                        n_garbage;
    logic [jsof_pkg::CFG_W-1:0]  n_idle;
    logic                        n_out_valid;
    jsof_pkg::t_out_item         n_out_item;

    logic                        go;
    logic [jsof_pkg::CFG_W-1:0]  idle_eff;
    logic [COUNT_BITS-1:0]       cnt_inc;
    logic [COUNT_BITS-1:0]       depth_dec;
    jsof_pkg::t_lead             lead_nxt;
    logic                        flush;

    function automatic jsof_pkg::t_lead lead_next(input jsof_pkg::t_lead s,
                                                  input jsof_pkg::t_bcls c);
        jsof_pkg::t_lead r;
        r = jsof_pkg::LM_OTHER;
        unique case (s)
            jsof_pkg::LM_NONE: begin
                if (c == jsof_pkg::BC_WS) begin
                    r = jsof_pkg::LM_NONE;
                end else if (c == jsof_pkg::BC_N) begin
                    r = jsof_pkg::LM_N;
                end else if (c == jsof_pkg::BC_LBRACE || c == jsof_pkg::BC_QUOTE) begin
                    r = jsof_pkg::LM_CLEAR;
                end
            end
            jsof_pkg::LM_N: begin
                if (c == jsof_pkg::BC_A) begin
                    r = jsof_pkg::LM_NA;
                end else if (c == jsof_pkg::BC_O) begin
                    r = jsof_pkg::LM_NO;
                end
            end
            jsof_pkg::LM_NA: begin
                if (c == jsof_pkg::BC_V) r = jsof_pkg::LM_NAV;
            end
            jsof_pkg::LM_NAV: begin
                if (c == jsof_pkg::BC_UNDER) r = jsof_pkg::LM_HIT;
            end
            jsof_pkg::LM_NO: begin
                if (c == jsof_pkg::BC_D) r = jsof_pkg::LM_NOD;
            end
            jsof_pkg::LM_NOD: begin
                if (c == jsof_pkg::BC_E) r = jsof_pkg::LM_NODE;
            end
            jsof_pkg::LM_NODE: begin
                if (c == jsof_pkg::BC_UNDER) r = jsof_pkg::LM_HIT;
            end
            jsof_pkg::LM_HIT:   r = jsof_pkg::LM_HIT;
            jsof_pkg::LM_CLEAR: r = jsof_pkg::LM_CLEAR;
            default:            r = jsof_pkg::LM_OTHER;
        endcase
        return r;
    endfunction

    assign go        = !i_q_stat.empty && (!r_out_valid || !i_out_stall);
    assign idle_eff  = (r_cnt == '0) ? '0 : r_idle;
    assign cnt_inc   = (r_cnt != CNT_MAX) ? r_cnt + 1'b1 : r_cnt;
    assign depth_dec = (r_depth != '0) ? r_depth - 1'b1 : r_depth;
    assign lead_nxt  = lead_next(r_lead, i_head.cls);
    assign flush     = (lead_nxt == jsof_pkg::LM_HIT)
                    || (CMP_W'(cnt_inc) > CMP_W'(i_cfg.size_limit))
                    || (idle_eff > i_cfg.stale_ticks)
                    || ((lead_nxt != jsof_pkg::LM_CLEAR)
                        && (CMP_W'(cnt_inc) >= CMP_W'(i_cfg.unclear_limit)));

    always_comb begin
        n_cnt       = r_cnt;
        n_inside    = r_inside;
        n_depth     = r_depth;
        n_lead      = r_lead;
        n_garbage   = r_garbage;
        n_idle      = r_idle;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        if (go) begin
            if (i_head.kind) begin
                if (r_idle != '1) n_idle = r_idle + 1'b1;
            end else begin
                n_cnt                  = cnt_inc;
                n_lead                 = lead_nxt;
                n_idle                 = idle_eff;
                n_out_item             = '0;
                n_out_item.byte_out    = i_head.byte_val;
                if (flush) begin
                    n_out_item.flushed = 1'b1;
                    n_out_valid        = 1'b1;
                    n_cnt              = '0;
                    n_inside           = 1'b0;
                    n_depth            = '0;
                    n_lead             = jsof_pkg::LM_NONE;
                    n_garbage          = 1'b0;
                    n_idle             = '0;
                end else if (!r_inside) begin
                    if (i_head.cls != jsof_pkg::BC_LBRACE) begin
                        if (i_head.cls != jsof_pkg::BC_WS) n_garbage = 1'b1;
                    end else begin
                        n_inside              = 1'b1;
                        n_depth               = COUNT_BITS'(1);
                        n_out_item.in_object  = 1'b1;
                        n_out_item.object_bad = r_garbage;
                        n_out_valid           = 1'b1;
                    end
                end else begin
                    n_out_item.in_object  = 1'b1;
                    n_out_item.object_bad = r_garbage;
                    n_out_valid           = 1'b1;
                    if (i_head.cls == jsof_pkg::BC_LBRACE) begin
                        if (r_depth != CNT_MAX) n_depth = r_depth + 1'b1;
                    end else if (i_head.cls == jsof_pkg::BC_RBRACE) begin
                        n_depth = depth_dec;
                        if (depth_dec == '0) begin
                            n_out_item.object_last = 1'b1;
                            n_cnt                  = '0;
                            n_inside               = 1'b0;
                            n_lead                 = jsof_pkg::LM_NONE;
                            n_garbage              = 1'b0;
                            n_idle                 = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_inside    <= 1'b0;
            r_depth     <= '0;
            r_lead      <= jsof_pkg::LM_NONE;
            r_garbage   <= 1'b0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_inside    <= n_inside;
            r_depth     <= n_depth;
            r_lead      <= n_lead;
            r_garbage   <= n_garbage;
            r_idle      <= n_idle;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_pop       = go;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/core/json_object_stream_framer_core.sv
// json object stream framer top level: config registers, front end, queue, back end
// an accepted beat is written into the queue; the back end pops it and registers any result
// throughput: one beat per cycle while the output is not stalled, bytes and ticks alike;
// set by the back end state loop (count increment and limit compares feeding the next beat)
// reset: synchronous, clears the queue, framing state and result valid, loads limit defaults
// depends on jsof_pkg, jsof_front, jsof_queue, jsof_back and the assertion header
`timescale 1ns / 1ps
`include "json_object_stream_framer_core_assert.svh"

module json_object_stream_framer_core #(
    parameter int COUNT_BITS = 17
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  jsof_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output jsof_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [jsof_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [jsof_pkg::CFG_W-1:0]        i_cfg_data
);

    jsof_pkg::t_cfg     r_cfg;
    jsof_pkg::t_cfg     n_cfg;
    jsof_pkg::t_q_stat  q_stat;
    jsof_pkg::t_q_entry push_entry;
    jsof_pkg::t_q_entry head;
    logic               push;
    logic               pop;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jsof_pkg::CFG_IDX_SIZE:    n_cfg.size_limit    = i_cfg_data;
                jsof_pkg::CFG_IDX_UNCLEAR: n_cfg.unclear_limit = i_cfg_data;
                jsof_pkg::CFG_IDX_STALE:   n_cfg.stale_ticks   = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_limit    <= jsof_pkg::SIZE_LIMIT_RST;
            r_cfg.unclear_limit <= jsof_pkg::UNCLEAR_LIMIT_RST;
            r_cfg.stale_ticks   <= jsof_pkg::STALE_TICKS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    jsof_front u_front (
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .i_q_stat     (q_stat),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_push_entry (push_entry)
    );

    jsof_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_head       (head),
        .o_stat       (q_stat)
    );

    jsof_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    `JSOF_ASSERT_IMPLY(a_flush_clean, i_clk, i_rst_n, o_out_valid && o_out_item.flushed, !o_out_item.in_object && !o_out_item.object_last && !o_out_item.object_bad, "flushed beat carries object flags")
    `JSOF_ASSERT_IMPLY(a_last_in_obj, i_clk, i_rst_n, o_out_valid && o_out_item.object_last, o_out_item.in_object && !o_out_item.flushed, "object last outside an object")
    `JSOF_ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, !o_out_valid && q_stat.empty, !o_out_valid, "result appeared with empty queue")

endmodule
